### src/bcd_signed_add_subtract_top_assert.svh
// Assertion macros for the signed BCD adder/subtractor.
// Each macro checks a property on the rising edge of clk, disabled during reset.
`ifndef BCD_SIGNED_ADD_SUBTRACT_TOP_ASSERT_SVH
`define BCD_SIGNED_ADD_SUBTRACT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold starting in the cycle after the antecedent.
`define BSAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bsas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsas_pkg
// Shared widths and transaction types for the signed BCD adder/subtractor.
// ----------------------------------------------------------------------------
package bsas_pkg;

  localparam int NUM_DIGITS = 16;
  localparam int FIELD_W    = 64;
  localparam int DIG_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = 5;

  typedef struct packed {
    logic [FIELD_W-1:0] a_digits;
    logic               a_negative;
    logic [FIELD_W-1:0] b_digits;
    logic               b_negative;
    logic               subtract;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_digits;
    logic               result_negative;
    logic [CNT_W-1:0]   digit_count;
    logic               overflow;
    logic               invalid_digit;
  } out_t;

  // Operands ready for the binary adder: x already carries +6 in every digit.
  typedef struct packed {
    logic [DIG_W-1:0] x_biased;
    logic [DIG_W-1:0] y;
    logic             carry_in;
    logic             add_mode;
    logic             sign;
    logic             invalid;
  } prep_t;

  typedef struct packed {
    logic [DIG_W-1:0] digits;
    logic             sign;
    logic             overflow;
    logic             invalid;
  } sum_t;

endpackage

### src/bsas_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsas_prep
// Checks digits, compares magnitudes and forms the adder operands.
// ----------------------------------------------------------------------------
module bsas_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  bsas_pkg::in_t  in_data,
  output logic           out_valid,
  output bsas_pkg::prep_t out_data
);

  logic [bsas_pkg::DIG_W-1:0] a_mag;
  logic [bsas_pkg::DIG_W-1:0] b_mag;
  logic [bsas_pkg::DIG_W-1:0] big;
  logic [bsas_pkg::DIG_W-1:0] small_mag;
  logic [bsas_pkg::DIG_W-1:0] x_raw;
  logic                       eff_b_neg;
  logic                       a_ge_b;
  bsas_pkg::prep_t            prep_nxt;
  bsas_pkg::prep_t            prep_r;
  logic                       valid_r;

  assign a_mag     = in_data.a_digits[bsas_pkg::DIG_W-1:0];
  assign b_mag     = in_data.b_digits[bsas_pkg::DIG_W-1:0];
  assign eff_b_neg = in_data.b_negative ^ in_data.subtract;
  // Plain binary order matches decimal order for valid BCD words.
  assign a_ge_b    = (a_mag >= b_mag);
  assign big       = a_ge_b ? a_mag : b_mag;
  assign small_mag = a_ge_b ? b_mag : a_mag;

  always_comb begin
    prep_nxt.invalid  = 1'b0;
    prep_nxt.add_mode = (in_data.a_negative == eff_b_neg);
    for (int i = 0; i < bsas_pkg::NUM_DIGITS; i++) begin
      if ((a_mag[4*i +: 4] > 4'd9) || (b_mag[4*i +: 4] > 4'd9)) begin
        prep_nxt.invalid = 1'b1;
      end
    end
    if (prep_nxt.add_mode) begin
      x_raw             = a_mag;
      prep_nxt.y        = b_mag;
      prep_nxt.carry_in = 1'b0;
      prep_nxt.sign     = in_data.a_negative;
    end else begin
      // Ten's complement of the smaller magnitude: nines complement plus one.
      x_raw             = big;
      for (int i = 0; i < bsas_pkg::NUM_DIGITS; i++) begin
        prep_nxt.y[4*i +: 4] = 4'd9 - small_mag[4*i +: 4];
      end
      prep_nxt.carry_in = 1'b1;
      prep_nxt.sign     = a_ge_b ? in_data.a_negative : eff_b_neg;
    end
    for (int i = 0; i < bsas_pkg::NUM_DIGITS; i++) begin
      prep_nxt.x_biased[4*i +: 4] = x_raw[4*i +: 4] + 4'd6;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prep_r <= prep_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = prep_r;

endmodule

### src/bsas_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsas_adder
// One binary add over the biased operands, then per-digit decimal correction.
// ----------------------------------------------------------------------------
module bsas_adder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  bsas_pkg::prep_t in_data,
  output logic            out_valid,
  output bsas_pkg::sum_t  out_data
);

  localparam int SUM_W = bsas_pkg::DIG_W + 1;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] carries;
  bsas_pkg::sum_t   sum_nxt;
  bsas_pkg::sum_t   sum_r;
  logic             valid_r;

  assign sum     = {1'b0, in_data.x_biased} + {1'b0, in_data.y}
                   + SUM_W'(in_data.carry_in);
  // Recover the carry into every bit position from the sum and its addends.
  assign carries = sum ^ {1'b0, in_data.x_biased} ^ {1'b0, in_data.y};

  always_comb begin
    for (int i = 0; i < bsas_pkg::NUM_DIGITS; i++) begin
      // A digit that produced no decimal carry still holds its +6 bias.
      if (carries[4*i+4]) begin
        sum_nxt.digits[4*i +: 4] = sum[4*i +: 4];
      end else begin
        sum_nxt.digits[4*i +: 4] = sum[4*i +: 4] - 4'd6;
      end
    end
    sum_nxt.overflow = in_data.add_mode & carries[bsas_pkg::DIG_W];
    sum_nxt.sign     = in_data.sign;
    sum_nxt.invalid  = in_data.invalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = sum_r;

endmodule

### src/bsas_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsas_norm
// Counts significant digits, fixes the sign of zero and blanks invalid input.
// ----------------------------------------------------------------------------
module bsas_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  bsas_pkg::sum_t in_data,
  output logic           out_valid,
  output bsas_pkg::out_t out_data
);

  logic [bsas_pkg::CNT_W-1:0] count;
  bsas_pkg::out_t             res_nxt;
  bsas_pkg::out_t             res_r;
  logic                       valid_r;

  always_comb begin
    count = '0;
    for (int i = 0; i < bsas_pkg::NUM_DIGITS; i++) begin
      if (in_data.digits[4*i +: 4] != 4'd0) begin
        count = bsas_pkg::CNT_W'(i + 1);
      end
    end
    if (in_data.invalid) begin
      res_nxt.result_digits   = '0;
      res_nxt.result_negative = 1'b0;
      res_nxt.digit_count     = '0;
      res_nxt.overflow        = 1'b0;
      res_nxt.invalid_digit   = 1'b1;
    end else begin
      res_nxt.result_digits   = bsas_pkg::FIELD_W'(in_data.digits);
      res_nxt.result_negative = in_data.sign && (count != '0);
      res_nxt.digit_count     = count;
      res_nxt.overflow        = in_data.overflow;
      res_nxt.invalid_digit   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;

endmodule

### src/bcd_signed_add_subtract_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_signed_add_subtract_top
// Sign-magnitude BCD adder/subtractor, one transaction per clock.
// ----------------------------------------------------------------------------
// A transaction is taken on every clock edge where start is high; busy is
// always low, so a new operand pair may follow in every cycle. Each result
// appears on out_payload after the four register stages below, flagged by
// out_valid for exactly one cycle, and must be captured then since the
// receiver cannot hold it off. The pipeline has four register stages: input
// capture, digit check with magnitude compare and operand forming, one wide
// binary add with decimal correction, and digit counting into the output
// register. Results leave in the order the transactions arrived.
module bcd_signed_add_subtract_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bsas_pkg::in_t  in_payload,
  output logic           out_valid,
  output bsas_pkg::out_t out_payload
);

  `include "bcd_signed_add_subtract_top_assert.svh"

  logic            in_valid_r;
  bsas_pkg::in_t   in_r;
  logic            prep_valid;
  bsas_pkg::prep_t prep_data;
  logic            sum_valid;
  bsas_pkg::sum_t  sum_data;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_payload;
  end

  bsas_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid_r),
    .in_data   (in_r),
    .out_valid (prep_valid),
    .out_data  (prep_data)
  );

  bsas_adder u_adder (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_data   (prep_data),
    .out_valid (sum_valid),
    .out_data  (sum_data)
  );

  bsas_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_valid),
    .in_data   (sum_data),
    .out_valid (out_valid),
    .out_data  (out_payload)
  );

  `BSAS_ASSERT_SAME(a_busy_low, 1'b1, !busy, "busy must stay low")
  `BSAS_ASSERT_NEXT(a_accept_capture, start && !busy, in_valid_r,
                    "accepted transaction was not captured")
  `BSAS_ASSERT_SAME(a_zero_positive, out_valid && (out_payload.digit_count == '0),
                    !out_payload.result_negative, "zero result must be positive")
  `BSAS_ASSERT_SAME(a_invalid_blank, out_valid && out_payload.invalid_digit,
                    (out_payload.result_digits == '0) && !out_payload.overflow,
                    "invalid input must give a blank result")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed BCD adder/subtractor. Operand pairs are
// sent in directed runs and random bursts. Each accepted transaction is
// predicted by a behavioral model of sign-magnitude decimal arithmetic, and
// each result strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [63:0] ALL_NINES = 64'h9999_9999_9999_9999;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  bsas_pkg::in_t  in_payload;
  logic           out_valid;
  bsas_pkg::out_t out_payload;

  bsas_pkg::out_t expected_sums[$];
  int             mismatches = 0;

  bcd_signed_add_subtract_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_payload(out_payload)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Behavioral decimal arithmetic on the used digits of both operands.
  function automatic bsas_pkg::out_t bcd_predict(bsas_pkg::in_t t);
    bsas_pkg::out_t r;
    logic [63:0]    big;
    logic [63:0]    lesser;
    logic [63:0]    acc;
    logic           b_sign;
    logic           a_larger;
    int             cmp;
    int unsigned    carry;
    int unsigned    s;
    int unsigned    y;
    int unsigned    cnt;
    r = '0;
    for (int i = 0; i < bsas_pkg::NUM_DIGITS; i++) begin
      if (t.a_digits[4*i +: 4] > 4'd9 || t.b_digits[4*i +: 4] > 4'd9) begin
        r.invalid_digit = 1'b1;
        return r;
      end
    end
    b_sign = t.b_negative ^ t.subtract;
    acc    = '0;
    carry  = 0;
    if (t.a_negative == b_sign) begin
      for (int i = 0; i < bsas_pkg::NUM_DIGITS; i++) begin
        s     = t.a_digits[4*i +: 4] + t.b_digits[4*i +: 4] + carry;
        carry = (s >= 10) ? 1 : 0;
        if (carry != 0) s = s - 10;
        acc[4*i +: 4] = s[3:0];
      end
      r.overflow        = (carry != 0);
      r.result_negative = t.a_negative;
    end else begin
      cmp = 0;
      for (int i = bsas_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
        if (cmp == 0 && t.a_digits[4*i +: 4] != t.b_digits[4*i +: 4])
          cmp = (t.a_digits[4*i +: 4] > t.b_digits[4*i +: 4]) ? 1 : -1;
      end
      a_larger = (cmp >= 0);
      big      = a_larger ? t.a_digits : t.b_digits;
      lesser   = a_larger ? t.b_digits : t.a_digits;
      for (int i = 0; i < bsas_pkg::NUM_DIGITS; i++) begin
        y = lesser[4*i +: 4] + carry;
        if (big[4*i +: 4] >= y) begin
          s     = big[4*i +: 4] - y;
          carry = 0;
        end else begin
          s     = big[4*i +: 4] + 10 - y;
          carry = 1;
        end
        acc[4*i +: 4] = s[3:0];
      end
      r.result_negative = a_larger ? t.a_negative : b_sign;
    end
    cnt = 0;
    for (int i = 0; i < bsas_pkg::NUM_DIGITS; i++)
      if (acc[4*i +: 4] != 4'd0) cnt = i + 1;
    if (cnt == 0) r.result_negative = 1'b0;
    r.result_digits = acc;
    r.digit_count   = cnt[bsas_pkg::CNT_W-1:0];
    return r;
  endfunction

  // Record the prediction for every transaction the block takes.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      expected_sums.push_back(bcd_predict(in_payload));
  end

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    bsas_pkg::out_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_sums.size() == 0) begin
        $error("result with no transaction outstanding: %0h", out_payload);
        mismatches++;
      end else begin
        exp_r = expected_sums.pop_front();
        compare_field("result_digits", exp_r.result_digits, out_payload.result_digits);
        compare_field("result_negative", 64'(exp_r.result_negative),
                      64'(out_payload.result_negative));
        compare_field("digit_count", 64'(exp_r.digit_count),
                      64'(out_payload.digit_count));
        compare_field("overflow", 64'(exp_r.overflow), 64'(out_payload.overflow));
        compare_field("invalid_digit", 64'(exp_r.invalid_digit),
                      64'(out_payload.invalid_digit));
      end
    end
  end

  function automatic bsas_pkg::in_t make_op(logic [63:0] a, logic an, logic [63:0] b,
                                            logic bn, logic sub);
    bsas_pkg::in_t t;
    t.a_digits   = a;
    t.a_negative = an;
    t.b_digits   = b;
    t.b_negative = bn;
    t.subtract   = sub;
    return t;
  endfunction

  function automatic logic [63:0] rand_bcd(int unsigned ndig);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < ndig; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    return v;
  endfunction

  function automatic bsas_pkg::in_t random_op();
    bsas_pkg::in_t t;
    int unsigned   kind;
    int unsigned   pos;
    logic [63:0]   tmp;
    t.a_negative = 1'($urandom_range(0, 1));
    t.b_negative = 1'($urandom_range(0, 1));
    t.subtract   = 1'($urandom_range(0, 1));
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      t.a_digits = rand_bcd($urandom_range(0, bsas_pkg::NUM_DIGITS));
      t.b_digits = rand_bcd($urandom_range(0, bsas_pkg::NUM_DIGITS));
    end else if (kind < 65) begin
      t.a_digits = rand_bcd(bsas_pkg::NUM_DIGITS);
      t.b_digits = rand_bcd(bsas_pkg::NUM_DIGITS);
    end else if (kind < 75) begin
      t.a_digits = rand_bcd($urandom_range(0, bsas_pkg::NUM_DIGITS));
      t.b_digits = t.a_digits;
    end else if (kind < 85) begin
      // Long runs of nines push carries and borrows across many digits.
      t.a_digits = ALL_NINES >> (4 * $urandom_range(0, bsas_pkg::NUM_DIGITS - 1));
      t.b_digits = rand_bcd($urandom_range(1, bsas_pkg::NUM_DIGITS));
      if ($urandom_range(0, 1) == 1) begin
        tmp        = t.a_digits;
        t.a_digits = t.b_digits;
        t.b_digits = tmp;
      end
    end else if (kind < 90) begin
      // Magnitudes that differ in at most one digit stress the compare.
      t.a_digits = rand_bcd(bsas_pkg::NUM_DIGITS);
      t.b_digits = t.a_digits;
      pos = $urandom_range(0, bsas_pkg::NUM_DIGITS - 1);
      t.b_digits[4*pos +: 4] = 4'($urandom_range(0, 9));
    end else if (kind < 96) begin
      t.a_digits = rand_bcd($urandom_range(0, bsas_pkg::NUM_DIGITS));
      t.b_digits = rand_bcd($urandom_range(0, bsas_pkg::NUM_DIGITS));
      pos = $urandom_range(0, bsas_pkg::NUM_DIGITS - 1);
      if ($urandom_range(0, 1) == 1) t.a_digits[4*pos +: 4] = 4'($urandom_range(10, 15));
      else t.b_digits[4*pos +: 4] = 4'($urandom_range(10, 15));
    end else begin
      t.a_digits = {$urandom, $urandom};
      t.b_digits = {$urandom, $urandom};
    end
    return t;
  endfunction

  // Start stays high between back-to-back transactions.
  task automatic send_item(input bsas_pkg::in_t item);
    @(negedge clk);
    start      <= 1'b1;
    in_payload <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    hold_off(1);
    while (expected_sums.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_item(make_op('0, 1'b0, '0, 1'b0, 1'b0));
    send_item(make_op('0, 1'b1, '0, 1'b1, 1'b0));
    send_item(make_op('0, 1'b1, '0, 1'b0, 1'b1));
    send_item(make_op(ALL_NINES, 1'b0, ALL_NINES, 1'b0, 1'b0));
    send_item(make_op(ALL_NINES, 1'b1, ALL_NINES, 1'b0, 1'b1));
    send_item(make_op(ALL_NINES, 1'b0, 64'h1, 1'b0, 1'b0));
    send_item(make_op(ALL_NINES, 1'b1, 64'h1, 1'b1, 1'b0));
    send_item(make_op(ALL_NINES, 1'b0, 64'h1, 1'b0, 1'b1));
    send_item(make_op(64'h1, 1'b0, ALL_NINES, 1'b0, 1'b1));
    drain();
  endtask

  task automatic test_sign_combinations();
    for (int k = 0; k < 8; k++)
      send_item(make_op(64'h0000_0000_0012_3456, k[2], 64'h0000_0000_0000_7890,
                        k[1], k[0]));
    drain();
  endtask

  task automatic test_compare_and_zero();
    // Equal magnitudes with opposite effective signs give a positive zero.
    send_item(make_op(64'h0000_0000_0000_4321, 1'b1, 64'h0000_0000_0000_4321, 1'b1, 1'b1));
    send_item(make_op(64'h1000_0000_0000_0000, 1'b0, 64'h0999_9999_9999_9999, 1'b1, 1'b0));
    send_item(make_op(64'h0000_0000_0000_0005, 1'b1, 64'h0000_0000_0000_0006, 1'b0, 1'b0));
    send_item(make_op(64'h5000_0000_0000_0001, 1'b0, 64'h5000_0000_0000_0002, 1'b0, 1'b1));
    drain();
  endtask

  task automatic test_invalid_digits();
    send_item(make_op(64'hF000_0000_0000_0000, 1'b0, 64'h1, 1'b0, 1'b0));
    send_item(make_op(64'h1, 1'b1, 64'h0000_0000_0000_000A, 1'b0, 1'b1));
    send_item(make_op(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
    send_item(make_op(64'h9999_9999_B999_9999, 1'b0, ALL_NINES, 1'b0, 1'b0));
    drain();
  endtask

  task automatic test_random_stream(input int unsigned total);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < total; i++) begin
        send_item(random_op());
        sent++;
        // Halfway through, let everything in flight come back first.
        if (sent == total / 2) drain();
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
    end
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_payload = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_sign_combinations();
    test_compare_and_zero();
    test_invalid_digits();
    test_random_stream(1900);
    repeat (12) @(posedge clk);
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
